// ===== design/rgbc_pkg.sv =====
// rgbc_pkg: shared types and constants of the 3x3 RGB convolution filter.
// Used by rgbc_front, rgbc_queue, rgbc_back and rgb_convolution_3x3.
// No dependencies.
`default_nettype none

package rgbc_pkg;

    localparam int PIX_W  = 24;
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QLW    = $clog2(QDEPTH + 1);

    localparam logic [2:0] CFG_COEF_TOP  = 3'd0;
    localparam logic [2:0] CFG_COEF_MID  = 3'd1;
    localparam logic [2:0] CFG_COEF_BOT  = 3'd2;
    localparam logic [2:0] CFG_TAP_OFF   = 3'd3;
    localparam logic [2:0] CFG_IMG_WIDTH = 3'd4;
    localparam logic [2:0] CFG_IMG_HGT   = 3'd5;

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_win win;
        logic last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_push;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [QLW-1:0] level;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/rgbc_front.sv =====
// rgbc_front: position counters, two line stores and the 3x3 window.
// Pushes masked windows into rgbc_queue. Depends on rgbc_pkg.
`default_nettype none

module rgbc_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [11:0]            i_image_width,
    input  wire  [12:0]            i_image_height,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire                    i_kind,
    input  wire  [7:0]             i_red_in,
    input  wire  [7:0]             i_green_in,
    input  wire  [7:0]             i_blue_in,
    input  rgbc_pkg::t_q_stat      i_q_stat,
    output rgbc_pkg::t_q_push      o_q_push
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [rgbc_pkg::PIX_W-1:0] r_upper_mem [MAX_WIDTH];
    logic [rgbc_pkg::PIX_W-1:0] r_lower_mem [MAX_WIDTH];

    logic [CW-1:0] r_in_col, n_in_col;
    logic [12:0]   r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [11:0]   r_out_row, n_out_row;

    logic                       r_s1_valid;
    logic [CW-1:0]              r_s1_col;
    logic [rgbc_pkg::PIX_W-1:0] r_s1_pix;
    logic                       r_s1_emit;
    logic [1:0]                 r_s1_rowok;
    logic [1:0]                 r_s1_colok;
    logic                       r_s1_last;
    logic [rgbc_pkg::PIX_W-1:0] r_up_rd, r_lo_rd;
    rgbc_pkg::t_win             r_win, n_win, win_masked;

    logic [15:0]   iw16, w16;
    logic [WW-1:0] w;
    logic [12:0]   h;
    logic          accept, wrap0, wrap1, emit, last;
    logic [CW-1:0] col;
    logic [12:0]   row0, or1;
    logic [WW-1:0] c1, oc1;
    logic [rgbc_pkg::PIX_W-1:0] pix;
    logic [1:0]    rowok, colok;

    assign o_in_ready = (32'(i_q_stat.level) + 32'(r_s1_valid)) < rgbc_pkg::QDEPTH;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        iw16 = 16'(i_image_width);
        if (iw16 < 16'd3) begin
            w16 = 16'd3;
        end else if (iw16 > 16'(MAX_WIDTH)) begin
            w16 = 16'(MAX_WIDTH);
        end else begin
            w16 = iw16;
        end
        w = w16[WW-1:0];
        if (i_image_height < 13'd3) begin
            h = 13'd3;
        end else if (i_image_height > 13'd4096) begin
            h = 13'd4096;
        end else begin
            h = i_image_height;
        end

        wrap0 = WW'(r_in_col) >= w;
        col   = wrap0 ? '0 : r_in_col;
        row0  = wrap0 ? r_in_row + 13'd1 : r_in_row;
        pix   = (!i_kind && row0 < h) ? {i_blue_in, i_green_in, i_red_in} : '0;
        emit  = (row0 >= 13'd2) || (row0 == 13'd1 && col != '0);

        c1       = WW'(col) + WW'(1);
        wrap1    = c1 >= w;
        n_in_col = wrap1 ? '0 : c1[CW-1:0];
        n_in_row = wrap1 ? row0 + 13'd1 : row0;

        or1      = 13'(r_out_row) + 13'd1;
        oc1      = WW'(r_out_col) + WW'(1);
        rowok[0] = r_out_row != '0;
        rowok[1] = or1 < h;
        colok[0] = r_out_col != '0;
        colok[1] = oc1 < w;
        last     = emit && (or1 >= h) && (oc1 >= w);

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (oc1 >= w) begin
                n_out_col = '0;
                n_out_row = r_out_row + 12'd1;
            end else begin
                n_out_col = oc1[CW-1:0];
            end
        end
        if (last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= col;
            r_s1_pix   <= pix;
            r_s1_emit  <= emit;
            r_s1_rowok <= rowok;
            r_s1_colok <= colok;
            r_s1_last  <= last;
        end
    end

    // line stores: upper takes the old lower entry in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd          <= r_upper_mem[col];
            r_lo_rd          <= r_lower_mem[col];
            r_lower_mem[col] <= pix;
        end
        if (r_s1_valid) begin
            r_upper_mem[r_s1_col] <= r_lo_rd;
        end
    end

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = r_up_rd;
        n_win[5] = r_lo_rd;
        n_win[8] = r_s1_pix;
        for (int k = 0; k < 9; k++) begin
            logic rok, cok;
            rok = (k / 3 == 0) ? r_s1_rowok[0] : ((k / 3 == 2) ? r_s1_rowok[1] : 1'b1);
            cok = (k % 3 == 0) ? r_s1_colok[0] : ((k % 3 == 2) ? r_s1_colok[1] : 1'b1);
            win_masked[k] = (rok && cok) ? n_win[k] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_q_push.valid     = r_s1_valid && r_s1_emit;
    assign o_q_push.item.win  = win_masked;
    assign o_q_push.item.last = r_s1_last;

endmodule

`default_nettype wire

// ===== design/rgbc_queue.sv =====
// rgbc_queue: short request queue between front and back.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rgbc_pkg::t_q_push  i_push,
    input  wire                i_pop,
    output rgbc_pkg::t_q_head  o_head,
    output rgbc_pkg::t_q_stat  o_stat
);

    rgbc_pkg::t_item                r_mem [rgbc_pkg::QDEPTH];
    logic [rgbc_pkg::QPW-1:0]       r_wr, r_rd;
    logic [rgbc_pkg::QLW-1:0]       r_count;
    logic                           push, pop;

    assign push = i_push.valid;
    assign pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + rgbc_pkg::QPW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + rgbc_pkg::QPW'(1);
            end
            r_count <= r_count + rgbc_pkg::QLW'(push) - rgbc_pkg::QLW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.item  = r_mem[r_rd];
    assign o_stat.level = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (32'(r_count) < rgbc_pkg::QDEPTH))
        else $error("queue push while full");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + rgbc_pkg::QLW'(1)))
        else $error("queue level did not rise on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - rgbc_pkg::QLW'(1)))
        else $error("queue level did not fall on pop");

endmodule

`default_nettype wire

// ===== design/rgbc_back.sv =====
// rgbc_back: per-channel multiply, accumulate and clamp pipeline with output register.
// Depends on rgbc_pkg.
`default_nettype none

module rgbc_back #(
    parameter int COEF_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [47:0]        i_coef_top,
    input  wire  [47:0]        i_coef_mid,
    input  wire  [47:0]        i_coef_bot,
    input  wire  signed [15:0] i_tap_offset,
    input  rgbc_pkg::t_q_head  i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [7:0]         o_red_out,
    output logic [7:0]         o_green_out,
    output logic [7:0]         o_blue_out,
    output logic               o_frame_last
);

    localparam int PW    = COEF_BITS + 9;
    localparam int ACC_W = COEF_BITS + 14;

    logic [2:0][47:0]              rows;
    logic signed [COEF_BITS-1:0]   coef [9];
    logic signed [PW-1:0]          n_prod [3][9];
    logic signed [ACC_W-1:0]       n_row [3][3];
    logic signed [ACC_W-1:0]       n_acc [3];
    logic signed [ACC_W-1:0]       off_x, off9;
    logic [2:0][7:0]               n_pix;

    logic                          r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic                          r_a_last, r_b_last, r_c_last, r_out_last;
    logic signed [PW-1:0]          r_a_prod [3][9];
    logic signed [ACC_W-1:0]       r_b_row [3][3];
    logic signed [ACC_W-1:0]       r_c_acc [3];
    logic [2:0][7:0]               r_out_pix;
    logic                          en;

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && i_head.valid;

    assign rows[0] = i_coef_top;
    assign rows[1] = i_coef_mid;
    assign rows[2] = i_coef_bot;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            coef[k] = rows[k / 3][16 * (k % 3) +: COEF_BITS];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                n_prod[ch][k] = coef[k] * $signed({1'b0, i_head.item.win[k][8*ch +: 8]});
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                n_row[ch][r] = ACC_W'(r_a_prod[ch][3*r]) + ACC_W'(r_a_prod[ch][3*r+1])
                             + ACC_W'(r_a_prod[ch][3*r+2]);
            end
        end
    end

    // offset is added once per tap
    assign off_x = ACC_W'(i_tap_offset);
    assign off9  = (off_x <<< 3) + off_x;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_acc[ch] = r_b_row[ch][0] + r_b_row[ch][1] + r_b_row[ch][2] + off9;
            if (r_c_acc[ch][ACC_W-1]) begin
                n_pix[ch] = 8'd0;
            end else if (|r_c_acc[ch][ACC_W-2:16]) begin
                n_pix[ch] = 8'd255;
            end else begin
                n_pix[ch] = r_c_acc[ch][15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_head.valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod   <= n_prod;
            r_a_last   <= i_head.item.last;
            r_b_row    <= n_row;
            r_b_last   <= r_a_last;
            r_c_acc    <= n_acc;
            r_c_last   <= r_b_last;
            r_out_pix  <= n_pix;
            r_out_last <= r_c_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_out_pix[0];
    assign o_green_out  = r_out_pix[1];
    assign o_blue_out   = r_out_pix[2];
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

// ===== design/rgb_convolution_3x3.sv =====
// rgb_convolution_3x3: top level of the 3x3 RGB convolution filter.
// Holds the configuration registers; instantiates rgbc_front, rgbc_queue, rgbc_back.
//
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes one pixel request per cycle in raster
//  order while o_in_ready is high; i_kind = 1 marks a padding tick. A frame takes
//  W*H + W + 1 input requests. Output channel (o_out_valid / i_out_ready) gives one
//  filtered pixel per cycle while i_out_ready is high; o_frame_last marks the final
//  pixel of the frame. Throughput: one request per cycle in and out when neither side
//  stalls, set by one line store read and write per request in the front and the
//  four-stage multiply/add pipeline in the back. Results lag the input by one row and
//  one pixel.
//  Receiver stall: the back pipeline holds, the four-entry queue fills and o_in_ready
//  drops once the queue plus the request in the front stage would not fit.
//  Reset (i_rst_n low, synchronous) clears counters, window and pipeline valids and
//  loads the identity kernel, zero offset, 640 x 480. Line stores are not cleared.
//  Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
`default_nettype none

module rgb_convolution_3x3 #(
    parameter int MAX_WIDTH = 2048,
    parameter int COEF_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [47:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_kind,
    input  wire  [7:0]  i_red_in,
    input  wire  [7:0]  i_green_in,
    input  wire  [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_frame_last
);

    logic [47:0]        r_coef_top, r_coef_mid, r_coef_bot;
    logic signed [15:0] r_tap_offset;
    logic [11:0]        r_image_width;
    logic [12:0]        r_image_height;

    rgbc_pkg::t_q_push  q_push;
    rgbc_pkg::t_q_head  q_head;
    rgbc_pkg::t_q_stat  q_stat;
    logic               q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top     <= 48'd0;
            r_coef_mid     <= 48'h000001000000;
            r_coef_bot     <= 48'd0;
            r_tap_offset   <= 16'sd0;
            r_image_width  <= 12'd640;
            r_image_height <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rgbc_pkg::CFG_COEF_TOP:  r_coef_top     <= i_cfg_data;
                rgbc_pkg::CFG_COEF_MID:  r_coef_mid     <= i_cfg_data;
                rgbc_pkg::CFG_COEF_BOT:  r_coef_bot     <= i_cfg_data;
                rgbc_pkg::CFG_TAP_OFF:   r_tap_offset   <= i_cfg_data[15:0];
                rgbc_pkg::CFG_IMG_WIDTH: r_image_width  <= i_cfg_data[11:0];
                rgbc_pkg::CFG_IMG_HGT:   r_image_height <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    rgbc_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_width (r_image_width),
        .i_image_height(r_image_height),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push)
    );

    rgbc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_stat (q_stat)
    );

    rgbc_back #(
        .COEF_BITS(COEF_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef_top  (r_coef_top),
        .i_coef_mid  (r_coef_mid),
        .i_coef_bot  (r_coef_bot),
        .i_tap_offset(r_tap_offset),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_last(o_frame_last)
    );

endmodule

`default_nettype wire
